// ===== design/i2p_pkg.sv =====
// Shared types, character codes and precedence function for the infix to
// postfix converter. No dependencies.
package i2p_pkg;

  localparam int STACK_DEPTH = 32;
  localparam int AW = $clog2(STACK_DEPTH);
  localparam int CW = $clog2(STACK_DEPTH + 1);

  localparam logic [7:0] CH_POW   = 8'h5E;
  localparam logic [7:0] CH_MUL   = 8'h2A;
  localparam logic [7:0] CH_DIV   = 8'h2F;
  localparam logic [7:0] CH_ADD   = 8'h2B;
  localparam logic [7:0] CH_SUB   = 8'h2D;
  localparam logic [7:0] CH_OPEN  = 8'h28;
  localparam logic [7:0] CH_CLOSE = 8'h29;

  localparam logic [1:0] ERR_NONE      = 2'd0;
  localparam logic [1:0] ERR_OVERFLOW  = 2'd1;
  localparam logic [1:0] ERR_UNMATCHED = 2'd2;

  typedef struct packed {
    logic [7:0] in_char;
    logic       end_of_expression;
  } infix_word_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       char_present;
    logic       last;
    logic [1:0] error;
  } postfix_word_t;

  typedef enum logic {
    ST_IDLE,
    ST_WORK
  } state_t;

  typedef enum logic [2:0] {
    SEL_TOP,
    SEL_CHAR,
    SEL_EMPTY_END,
    SEL_OVERFLOW,
    SEL_UNMATCHED
  } emit_sel_t;

  typedef struct packed {
    logic      load;
    logic      push;
    logic      pop;
    logic      emit;
    emit_sel_t sel;
    logic      last;
  } cmd_t;

  typedef struct packed {
    logic is_eoe;
    logic is_operand;
    logic is_close;
    logic is_op;
    logic empty;
    logic full;
    logic one_left;
    logic paren_none;
    logic top_is_open;
    logic top_ge;
    logic out_free;
  } status_t;

  // 0 for operands and parentheses
  function automatic logic [1:0] prec_of(input logic [7:0] c);
    logic [1:0] p;
    case (c)
      CH_POW:          p = 2'd3;
      CH_MUL, CH_DIV:  p = 2'd2;
      CH_ADD, CH_SUB:  p = 2'd1;
      default:         p = 2'd0;
    endcase
    return p;
  endfunction

endpackage

// ===== design/infix_to_postfix_converter.sv =====
// Top level of the shunting-yard infix to postfix converter.
// Depends on i2p_pkg, i2p_ctrl and i2p_dp.
//
//   channel  ports                                    word type
//   infix    infix_valid, infix_stall, infix_word     infix_word_t
//   postfix  postfix_valid, postfix_stall, postfix_word  postfix_word_t
//
// One word is taken, then worked on from the next cycle: operands and errors
// are emitted, operators pushed and an end marker pops every stacked entry.
// Pops go one a cycle while the output is not stalled, set by the single stack
// read port and the one-word output register. Reset empties the stack and drops
// postfix_valid. A stalled output holds the controller in its work state while
// a word waits to go out; infix_stall stays high until the word is done.
module infix_to_postfix_converter (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   infix_valid,
  output logic                   infix_stall,
  input  i2p_pkg::infix_word_t   infix_word,
  output logic                   postfix_valid,
  input  logic                   postfix_stall,
  output i2p_pkg::postfix_word_t postfix_word
);

  i2p_pkg::cmd_t    cmd;
  i2p_pkg::status_t st;
  logic             busy;

  assign infix_stall = busy;

  i2p_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .infix_valid (infix_valid),
    .st          (st),
    .cmd         (cmd),
    .busy        (busy)
  );

  i2p_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .infix_word    (infix_word),
    .cmd           (cmd),
    .postfix_stall (postfix_stall),
    .st            (st),
    .postfix_valid (postfix_valid),
    .postfix_word  (postfix_word)
  );

endmodule

// ===== design/i2p_ctrl.sv =====
// Controller state machine for the infix to postfix converter.
// Depends on i2p_pkg.
module i2p_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             infix_valid,
  input  i2p_pkg::status_t st,
  output i2p_pkg::cmd_t    cmd,
  output logic             busy
);

  i2p_pkg::state_t state;
  i2p_pkg::state_t state_next;
  logic            finish;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= i2p_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    case (state)
      i2p_pkg::ST_IDLE: state_next = infix_valid ? i2p_pkg::ST_WORK : i2p_pkg::ST_IDLE;
      i2p_pkg::ST_WORK: state_next = finish ? i2p_pkg::ST_IDLE : i2p_pkg::ST_WORK;
      default:          state_next = i2p_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd    = '0;
    cmd.sel = i2p_pkg::SEL_TOP;
    finish = 1'b0;
    busy   = 1'b1;
    case (state)
      i2p_pkg::ST_IDLE: begin
        busy     = 1'b0;
        cmd.load = infix_valid;
      end
      i2p_pkg::ST_WORK: begin
        if (st.is_eoe) begin
          if (st.empty) begin
            cmd.emit = st.out_free;
            cmd.sel  = i2p_pkg::SEL_EMPTY_END;
            cmd.last = 1'b1;
            finish   = st.out_free;
          end else begin
            cmd.emit = st.out_free;
            cmd.pop  = st.out_free;
            cmd.sel  = i2p_pkg::SEL_TOP;
            cmd.last = st.one_left;
            finish   = st.out_free && st.one_left;
          end
        end else if (st.is_operand) begin
          cmd.emit = st.out_free;
          cmd.sel  = i2p_pkg::SEL_CHAR;
          finish   = st.out_free;
        end else if (st.is_close) begin
          if (st.paren_none) begin
            cmd.emit = st.out_free;
            cmd.sel  = i2p_pkg::SEL_UNMATCHED;
            finish   = st.out_free;
          end else if (st.top_is_open) begin
            cmd.pop = 1'b1;
            finish  = 1'b1;
          end else begin
            cmd.emit = st.out_free;
            cmd.pop  = st.out_free;
            cmd.sel  = i2p_pkg::SEL_TOP;
          end
        end else if (st.is_op && !st.empty && st.top_ge) begin
          cmd.emit = st.out_free;
          cmd.pop  = st.out_free;
          cmd.sel  = i2p_pkg::SEL_TOP;
        end else if (st.full) begin
          cmd.emit = st.out_free;
          cmd.sel  = i2p_pkg::SEL_OVERFLOW;
          finish   = st.out_free;
        end else begin
          cmd.push = 1'b1;
          finish   = 1'b1;
        end
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

endmodule

// ===== design/i2p_dp.sv =====
// Datapath: input word register, operator stack, counters and output register.
// Depends on i2p_pkg.
module i2p_dp (
  input  logic                   clk,
  input  logic                   rst,
  input  i2p_pkg::infix_word_t   infix_word,
  input  i2p_pkg::cmd_t          cmd,
  input  logic                   postfix_stall,
  output i2p_pkg::status_t       st,
  output logic                   postfix_valid,
  output i2p_pkg::postfix_word_t postfix_word
);

  logic [7:0]                 cur_char;
  logic                       cur_eoe;
  logic [7:0]                 stack_regs [i2p_pkg::STACK_DEPTH];
  logic [i2p_pkg::CW-1:0]     count;
  logic [i2p_pkg::CW-1:0]     paren_count;
  logic [i2p_pkg::CW-1:0]     top_pos;
  logic [7:0]                 top_char;
  logic [1:0]                 cur_prec;
  logic                       cur_open;
  i2p_pkg::postfix_word_t     word_next;

  assign top_pos  = count - i2p_pkg::CW'(1);
  assign top_char = stack_regs[top_pos[i2p_pkg::AW-1:0]];
  assign cur_prec = i2p_pkg::prec_of(cur_char);
  assign cur_open = (cur_char == i2p_pkg::CH_OPEN);

  always_comb begin
    st.is_eoe      = cur_eoe;
    st.is_close    = (cur_char == i2p_pkg::CH_CLOSE);
    st.is_op       = (cur_prec != 2'd0);
    st.is_operand  = !st.is_op && !cur_open && !st.is_close;
    st.empty       = (count == '0);
    st.full        = (count == i2p_pkg::CW'(i2p_pkg::STACK_DEPTH));
    st.one_left    = (count == i2p_pkg::CW'(1));
    st.paren_none  = (paren_count == '0);
    st.top_is_open = (top_char == i2p_pkg::CH_OPEN);
    st.top_ge      = (i2p_pkg::prec_of(top_char) >= cur_prec);
    st.out_free    = !postfix_valid || !postfix_stall;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cur_char <= infix_word.in_char;
      cur_eoe  <= infix_word.end_of_expression;
    end
    if (cmd.push) begin
      stack_regs[count[i2p_pkg::AW-1:0]] <= cur_char;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count       <= '0;
      paren_count <= '0;
    end else if (cmd.push) begin
      count <= count + i2p_pkg::CW'(1);
      if (cur_open) begin
        paren_count <= paren_count + i2p_pkg::CW'(1);
      end
    end else if (cmd.pop) begin
      count <= top_pos;
      if (st.top_is_open) begin
        paren_count <= paren_count - i2p_pkg::CW'(1);
      end
    end
  end

  always_comb begin
    word_next.last = cmd.last;
    case (cmd.sel)
      i2p_pkg::SEL_TOP: begin
        word_next.out_char     = top_char;
        word_next.char_present = 1'b1;
        word_next.error        = i2p_pkg::ERR_NONE;
      end
      i2p_pkg::SEL_CHAR: begin
        word_next.out_char     = cur_char;
        word_next.char_present = 1'b1;
        word_next.error        = i2p_pkg::ERR_NONE;
      end
      i2p_pkg::SEL_OVERFLOW: begin
        word_next.out_char     = 8'd0;
        word_next.char_present = 1'b0;
        word_next.error        = i2p_pkg::ERR_OVERFLOW;
      end
      i2p_pkg::SEL_UNMATCHED: begin
        word_next.out_char     = 8'd0;
        word_next.char_present = 1'b0;
        word_next.error        = i2p_pkg::ERR_UNMATCHED;
      end
      default: begin
        word_next.out_char     = 8'd0;
        word_next.char_present = 1'b0;
        word_next.error        = i2p_pkg::ERR_NONE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      postfix_valid <= 1'b0;
    end else if (cmd.emit) begin
      postfix_valid <= 1'b1;
    end else if (!postfix_stall) begin
      postfix_valid <= 1'b0;
    end
    if (cmd.emit) begin
      postfix_word <= word_next;
    end
  end

endmodule
